[hdl/fcgrd_pkg.sv]
// fcgrd_pkg: shared types and constants of the record deframer
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps

package fcgrd_pkg;

    // record types and begin-request body values
    localparam logic [7:0]  KIND_BEGIN     = 8'd1;
    localparam logic [7:0]  KIND_PARAMS    = 8'd4;
    localparam logic [7:0]  KIND_STDIN     = 8'd5;
    localparam logic [15:0] ROLE_RESPONDER = 16'd1;
    localparam logic [15:0] BEGIN_MIN_LEFT = 16'd6;

    // event codes on the output channel
    localparam logic [3:0] EV_NAME_LEN    = 4'd0;
    localparam logic [3:0] EV_VALUE_LEN   = 4'd1;
    localparam logic [3:0] EV_NAME_BYTE   = 4'd2;
    localparam logic [3:0] EV_VALUE_BYTE  = 4'd3;
    localparam logic [3:0] EV_PARAMS_DONE = 4'd4;
    localparam logic [3:0] EV_PARAMS_ERR  = 4'd5;
    localparam logic [3:0] EV_STDIN_BYTE  = 4'd6;
    localparam logic [3:0] EV_REQ_DONE    = 4'd7;
    localparam logic [3:0] EV_BEGIN_OK    = 4'd8;

    // commands passed from the framer to the back end
    localparam logic [1:0] CMD_DIRECT      = 2'd0;
    localparam logic [1:0] CMD_PARAMS_BYTE = 2'd1;
    localparam logic [1:0] CMD_PARAMS_END  = 2'd2;

    // queue between the two halves
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one queued command: for direct events data holds the event code
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } fcgrd_item_t;

endpackage

[hdl/fcgrd_if.sv]
// fcgrd_in_if / fcgrd_out_if: valid-ready channels of the record deframer
// no dependencies
`timescale 1ns / 1ps

interface fcgrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcgrd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

[hdl/fastcgi_record_deframer.sv]
// fastcgi_record_deframer: top level of the request record deframer
// depends on fcgrd_pkg, fcgrd_if, fcgrd_front, fcgrd_queue, fcgrd_back
//
//   channel   dir  payload            transfer when
//   in_ch     in   data_byte [7:0]    in_ch.valid && in_ch.ready
//   out_ch    out  event_res [3:0]    out_ch.valid && out_ch.ready
//
// one byte a cycle unless the queue is full; the framer classifies a byte in its accept cycle
// an event passes through a queue slot, then the output register
// only params body bytes and event-raising bytes take a queue slot
// in_ch.ready drops only when the four-entry queue is full (output stalled)
// rst_n clears framing and pair state asynchronously; no clearing pass
`timescale 1ns / 1ps

module fastcgi_record_deframer
    import fcgrd_pkg::*;
#(
    parameter int PAIR_LEN_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    fcgrd_in_if.sink    in_ch,
    fcgrd_out_if.source out_ch
);

    logic        q_full, q_not_empty, push, pop;
    fcgrd_item_t push_item, q_head;

    // header, body and padding framing
    fcgrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_byte   (in_ch.data_byte),
        .in_ready  (in_ch.ready),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    fcgrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // pair decoding and result register
    fcgrd_back #(
        .PAIR_LEN_BITS (PAIR_LEN_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_ch.valid),
        .out_event   (out_ch.event_res),
        .out_ready   (out_ch.ready)
    );

endmodule

[hdl/fcgrd_front.sv]
// fcgrd_front: record framer, walks header, body and padding, one byte a cycle
// unless the queue is full; depends on fcgrd_pkg; pushes commands into fcgrd_queue
`timescale 1ns / 1ps

module fcgrd_front
    import fcgrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    output logic        in_ready,
    input  logic        q_full,
    output logic        push,
    output fcgrd_item_t push_item
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_PAD    = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  hpos_reg, hpos_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] body_left_reg, body_left_next;
    logic [1:0]  body_off_reg, body_off_next;
    logic [7:0]  pad_left_reg, pad_left_next;
    logic [15:0] role_reg, role_next;
    logic        take;
    logic [1:0]  after_body;

    assign in_ready   = !q_full;
    assign take       = in_valid && in_ready;
    assign after_body = (pad_left_reg != 8'd0) ? PH_PAD : PH_HEADER;

    // per-byte framing and classification
    always_comb
    begin
        phase_next     = phase_reg;
        hpos_next      = hpos_reg;
        kind_next      = kind_reg;
        body_left_next = body_left_reg;
        body_off_next  = body_off_reg;
        pad_left_next  = pad_left_reg;
        role_next      = role_reg;
        push           = 1'b0;
        push_item.cmd  = CMD_DIRECT;
        push_item.data = in_byte;
        if (take)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    case (hpos_reg)
                        3'd1: kind_next = in_byte;
                        3'd4: body_left_next = {in_byte, 8'h00};
                        3'd5: body_left_next = {body_left_reg[15:8], in_byte};
                        3'd6: pad_left_next = in_byte;
                        default: ;
                    endcase
                    if (hpos_reg == 3'd7)
                    begin
                        hpos_next     = 3'd0;
                        body_off_next = 2'd0;
                        if (body_left_reg != 16'd0)
                        begin
                            phase_next = PH_BODY;
                        end
                        else
                        begin
                            phase_next = after_body;
                            if (kind_reg == KIND_PARAMS)
                            begin
                                push          = 1'b1;
                                push_item.cmd = CMD_PARAMS_END;
                            end
                            else if (kind_reg == KIND_STDIN)
                            begin
                                push           = 1'b1;
                                push_item.data = {4'h0, EV_REQ_DONE};
                            end
                        end
                    end
                    else
                    begin
                        hpos_next = hpos_reg + 3'd1;
                    end
                end
                PH_BODY:
                begin
                    if (kind_reg == KIND_BEGIN)
                    begin
                        case (body_off_reg)
                            2'd0: role_next = {in_byte, 8'h00};
                            2'd1: role_next = {role_reg[15:8], in_byte};
                            2'd2:
                            begin
                                if (body_left_reg >= BEGIN_MIN_LEFT &&
                                    role_reg == ROLE_RESPONDER)
                                begin
                                    push           = 1'b1;
                                    push_item.data = {4'h0, EV_BEGIN_OK};
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (kind_reg == KIND_PARAMS)
                    begin
                        push          = 1'b1;
                        push_item.cmd = CMD_PARAMS_BYTE;
                    end
                    else if (kind_reg == KIND_STDIN)
                    begin
                        push           = 1'b1;
                        push_item.data = {4'h0, EV_STDIN_BYTE};
                    end
                    // offset saturates: only the first three body bytes matter
                    if (body_off_reg != 2'd3)
                    begin
                        body_off_next = body_off_reg + 2'd1;
                    end
                    body_left_next = body_left_reg - 16'd1;
                    if (body_left_reg == 16'd1)
                    begin
                        phase_next = after_body;
                    end
                end
                PH_PAD:
                begin
                    pad_left_next = pad_left_reg - 8'd1;
                    if (pad_left_reg == 8'd1)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hpos_reg      <= 3'd0;
            kind_reg      <= 8'd0;
            body_left_reg <= 16'd0;
            body_off_reg  <= 2'd0;
            pad_left_reg  <= 8'd0;
            role_reg      <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hpos_reg      <= hpos_next;
            kind_reg      <= kind_next;
            body_left_reg <= body_left_next;
            body_off_reg  <= body_off_next;
            pad_left_reg  <= pad_left_next;
            role_reg      <= role_next;
        end
    end

endmodule

[hdl/fcgrd_queue.sv]
// fcgrd_queue: short command queue between framer and pair decoder
// depends on fcgrd_pkg for the item type and depth
`timescale 1ns / 1ps

module fcgrd_queue
    import fcgrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fcgrd_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output fcgrd_item_t head
);

    fcgrd_item_t           slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/fcgrd_back.sv]
// fcgrd_back: name-value pair decoder and output event register
// depends on fcgrd_pkg; pops commands from fcgrd_queue
`timescale 1ns / 1ps

module fcgrd_back
    import fcgrd_pkg::*;
#(
    parameter int PAIR_LEN_BITS = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  fcgrd_item_t q_head,
    output logic        pop,
    output logic        out_valid,
    output logic [3:0]  out_event,
    input  logic        out_ready
);

    localparam logic [2:0] PP_NAME_LEN        = 3'd0;
    localparam logic [2:0] PP_NAME_LEN_MORE   = 3'd1;
    localparam logic [2:0] PP_VALUE_LEN       = 3'd2;
    localparam logic [2:0] PP_VALUE_LEN_MORE  = 3'd3;
    localparam logic [2:0] PP_NAME            = 3'd4;
    localparam logic [2:0] PP_VALUE           = 3'd5;

    logic [2:0]               pp_reg, pp_next;
    logic [1:0]               lbytes_reg, lbytes_next;
    logic [PAIR_LEN_BITS-1:0] acc_reg, acc_next;
    logic [PAIR_LEN_BITS-1:0] name_reg, name_next;
    logic [PAIR_LEN_BITS-1:0] value_reg, value_next;
    logic [PAIR_LEN_BITS+7:0] acc_shift;
    logic [1:0]               lbytes_dec;
    logic [PAIR_LEN_BITS-1:0] name_dec, value_dec;
    logic                     ev_fire;
    logic [3:0]               ev_code;
    logic                     out_valid_reg;
    logic [3:0]               out_event_reg;
    logic [7:0]               b;

    assign pop       = q_not_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign b         = q_head.data;
    assign acc_shift = {acc_reg, b};
    assign lbytes_dec = (lbytes_reg != 2'd0) ? lbytes_reg - 2'd1 : 2'd0;
    assign name_dec  = (name_reg != '0) ? name_reg - 1'b1 : name_reg;
    assign value_dec = (value_reg != '0) ? value_reg - 1'b1 : value_reg;

    // command execution
    always_comb
    begin
        pp_next     = pp_reg;
        lbytes_next = lbytes_reg;
        acc_next    = acc_reg;
        name_next   = name_reg;
        value_next  = value_reg;
        ev_fire     = 1'b0;
        ev_code     = q_head.data[3:0];
        if (pop)
        begin
            case (q_head.cmd)
                CMD_DIRECT:
                begin
                    ev_fire = 1'b1;
                end
                CMD_PARAMS_END:
                begin
                    ev_fire     = 1'b1;
                    ev_code     = (pp_reg == PP_NAME_LEN) ? EV_PARAMS_DONE : EV_PARAMS_ERR;
                    pp_next     = PP_NAME_LEN;
                    lbytes_next = 2'd0;
                    acc_next    = '0;
                    name_next   = '0;
                    value_next  = '0;
                end
                CMD_PARAMS_BYTE:
                begin
                    unique case (pp_reg)
                        PP_NAME_LEN, PP_VALUE_LEN:
                        begin
                            if (b[7])
                            begin
                                acc_next    = {{(PAIR_LEN_BITS-7){1'b0}}, b[6:0]};
                                lbytes_next = 2'd3;
                                pp_next     = (pp_reg == PP_NAME_LEN) ?
                                              PP_NAME_LEN_MORE : PP_VALUE_LEN_MORE;
                            end
                            else if (pp_reg == PP_NAME_LEN)
                            begin
                                name_next = {{(PAIR_LEN_BITS-8){1'b0}}, b};
                                pp_next   = PP_VALUE_LEN;
                                ev_fire   = 1'b1;
                                ev_code   = EV_NAME_LEN;
                            end
                            else
                            begin
                                value_next = {{(PAIR_LEN_BITS-8){1'b0}}, b};
                                ev_fire    = 1'b1;
                                ev_code    = EV_VALUE_LEN;
                                if (name_reg != '0)
                                    pp_next = PP_NAME;
                                else if (b != 8'd0)
                                    pp_next = PP_VALUE;
                                else
                                    pp_next = PP_NAME_LEN;
                            end
                        end
                        PP_NAME_LEN_MORE, PP_VALUE_LEN_MORE:
                        begin
                            acc_next    = acc_shift[PAIR_LEN_BITS-1:0];
                            lbytes_next = lbytes_dec;
                            if (lbytes_dec == 2'd0)
                            begin
                                acc_next = '0;
                                ev_fire  = 1'b1;
                                if (pp_reg == PP_NAME_LEN_MORE)
                                begin
                                    name_next = acc_shift[PAIR_LEN_BITS-1:0];
                                    pp_next   = PP_VALUE_LEN;
                                    ev_code   = EV_NAME_LEN;
                                end
                                else
                                begin
                                    value_next = acc_shift[PAIR_LEN_BITS-1:0];
                                    ev_code    = EV_VALUE_LEN;
                                    if (name_reg != '0)
                                        pp_next = PP_NAME;
                                    else if (acc_shift[PAIR_LEN_BITS-1:0] != '0)
                                        pp_next = PP_VALUE;
                                    else
                                        pp_next = PP_NAME_LEN;
                                end
                            end
                        end
                        PP_NAME:
                        begin
                            name_next = name_dec;
                            ev_fire   = 1'b1;
                            ev_code   = EV_NAME_BYTE;
                            if (name_dec == '0)
                                pp_next = (value_reg != '0) ? PP_VALUE : PP_NAME_LEN;
                        end
                        PP_VALUE:
                        begin
                            value_next = value_dec;
                            ev_fire    = 1'b1;
                            ev_code    = EV_VALUE_BYTE;
                            if (value_dec == '0)
                                pp_next = PP_NAME_LEN;
                        end
                        default:
                        begin
                            pp_next     = PP_NAME_LEN;
                            lbytes_next = 2'd0;
                            acc_next    = '0;
                            name_next   = '0;
                            value_next  = '0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg     <= PP_NAME_LEN;
            lbytes_reg <= 2'd0;
            acc_reg    <= '0;
            name_reg   <= '0;
            value_reg  <= '0;
        end
        else
        begin
            pp_reg     <= pp_next;
            lbytes_reg <= lbytes_next;
            acc_reg    <= acc_next;
            name_reg   <= name_next;
            value_reg  <= value_next;
        end
    end

    // output register: holds an event until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ev_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_fire)
        begin
            out_event_reg <= ev_code;
        end
    end

endmodule

[hdl/fcgrd_checker.sv]
// fcgrd_checker: port-level checks of the record deframer, bound to the top
// depends on fcgrd_pkg, fastcgi_record_deframer and the channel interfaces
`timescale 1ns / 1ps

module fcgrd_checker
    import fcgrd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_event
);

    // a stalled event holds its code
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_event))
        else $error("event changed while stalled");

    // only defined event codes leave the block
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_event <= EV_BEGIN_OK)
        else $error("undefined event code");

    // the queue is empty after reset, so input is open
    a_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

    // nothing is offered in the first cycle after reset
    a_quiet_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("event offered right after reset");

endmodule

bind fastcgi_record_deframer fcgrd_checker u_fcgrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_event (out_ch.event_res)
);

[test/tb_fastcgi_record_deframer.sv]
// tb_fastcgi_record_deframer: self-checking bench for the record deframer
// uses fcgrd_pkg, fcgrd_in_if / fcgrd_out_if and fastcgi_record_deframer from hdl
`timescale 1ns / 1ps

module tb_fastcgi_record_deframer
    import fcgrd_pkg::*;
();

    localparam int          PAIR_LEN_BITS = 31;
    localparam logic [30:0] LEN_MASK      = 31'((64'd1 << PAIR_LEN_BITS) - 64'd1);
    localparam logic [7:0]  FLAG_KEEP     = 8'd1;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_BYTES  = 750;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          CYCLE_LIMIT   = 500000;

    typedef logic [7:0] byte_q_t[$];
    typedef enum logic [1:0] {AT_HEADER, AT_BODY, AT_PAD} rec_at_e;
    typedef enum logic [2:0] {
        LEN_NAME, LEN_NAME_EXT, LEN_VALUE, LEN_VALUE_EXT, BYTES_NAME, BYTES_VALUE
    } pair_at_e;

    logic clk;
    logic rst_n;

    fcgrd_in_if  in_ch ();
    fcgrd_out_if out_ch ();

    fastcgi_record_deframer #(
        .PAIR_LEN_BITS (PAIR_LEN_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // expected events in order, and run bookkeeping
    logic [3:0] ev_pending[$];
    int         mismatches  = 0;
    int         bytes_sent  = 0;
    int         cycle_count = 0;
    bit         in_idle     = 1'b1;
    bit         out_idle    = 1'b1;
    bit         hold_output = 1'b0;
    byte_q_t    body_q;
    byte_q_t    no_body;

    // record framing state of the predictor
    rec_at_e     rec_at;
    logic [2:0]  hdr_idx;
    logic [7:0]  rec_kind;
    logic [15:0] body_left;
    logic [15:0] body_idx;
    logic [7:0]  pad_left;
    logic [15:0] begin_role;
    logic        keep_conn;

    // name-value pair decoder state of the predictor
    pair_at_e    pair_at;
    logic [1:0]  ext_left;
    logic [30:0] ext_len;
    logic [30:0] name_left;
    logic [30:0] value_left;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_fastcgi_record_deframer: done, errors");
            $finish;
        end
    end

    function automatic void clear_pairs();
        pair_at    = LEN_NAME;
        ext_left   = '0;
        ext_len    = '0;
        name_left  = '0;
        value_left = '0;
    endfunction

    function automatic void clear_deframer();
        rec_at     = AT_HEADER;
        hdr_idx    = '0;
        rec_kind   = '0;
        body_left  = '0;
        body_idx   = '0;
        pad_left   = '0;
        begin_role = '0;
        keep_conn  = 1'b0;
        clear_pairs();
    endfunction

    // both lengths known: go to name bytes, value bytes or the next pair
    function automatic void after_lengths();
        if (name_left != 0)
            pair_at = BYTES_NAME;
        else if (value_left != 0)
            pair_at = BYTES_VALUE;
        else
            pair_at = LEN_NAME;
    endfunction

    // one params body byte; returns 1 when it raises an event
    function automatic bit decode_pair_byte(input logic [7:0] b, output logic [3:0] ev);
        bit is_name;
        ev      = '0;
        is_name = (pair_at == LEN_NAME) || (pair_at == LEN_NAME_EXT);
        case (pair_at)
            LEN_NAME, LEN_VALUE:
            begin
                // top bit starts a four-byte length
                if (b[7])
                begin
                    ext_len  = 31'(b[6:0]);
                    ext_left = 2'd3;
                    pair_at  = is_name ? LEN_NAME_EXT : LEN_VALUE_EXT;
                    return 1'b0;
                end
                if (is_name)
                begin
                    name_left = 31'(b) & LEN_MASK;
                    pair_at   = LEN_VALUE;
                    ev        = EV_NAME_LEN;
                    return 1'b1;
                end
                value_left = 31'(b) & LEN_MASK;
                after_lengths();
                ev = EV_VALUE_LEN;
                return 1'b1;
            end
            LEN_NAME_EXT, LEN_VALUE_EXT:
            begin
                ext_len = {ext_len[22:0], b};
                if (ext_left != 0)
                    ext_left--;
                if (ext_left != 0)
                    return 1'b0;
                if (is_name)
                begin
                    name_left = ext_len & LEN_MASK;
                    ext_len   = '0;
                    pair_at   = LEN_VALUE;
                    ev        = EV_NAME_LEN;
                    return 1'b1;
                end
                value_left = ext_len & LEN_MASK;
                ext_len    = '0;
                after_lengths();
                ev = EV_VALUE_LEN;
                return 1'b1;
            end
            BYTES_NAME:
            begin
                if (name_left != 0)
                    name_left--;
                if (name_left == 0)
                    pair_at = (value_left != 0) ? BYTES_VALUE : LEN_NAME;
                ev = EV_NAME_BYTE;
                return 1'b1;
            end
            BYTES_VALUE:
            begin
                if (value_left != 0)
                    value_left--;
                if (value_left == 0)
                    pair_at = LEN_NAME;
                ev = EV_VALUE_BYTE;
                return 1'b1;
            end
            default:
            begin
                clear_pairs();
                return 1'b0;
            end
        endcase
    endfunction

    // advance the predictor by one accepted byte and queue its event
    function automatic void step_deframer(input logic [7:0] b);
        bit         fire;
        logic [3:0] ev;
        fire = 1'b0;
        ev   = '0;
        case (rec_at)
            AT_HEADER:
            begin
                case (hdr_idx)
                    3'd1:    rec_kind  = b;
                    3'd4:    body_left = {b, 8'h00};
                    3'd5:    body_left = {body_left[15:8], b};
                    3'd6:    pad_left  = b;
                    default: ;
                endcase
                if (hdr_idx == 3'd7)
                begin
                    hdr_idx  = '0;
                    body_idx = '0;
                    if (body_left != 0)
                        rec_at = AT_BODY;
                    else
                    begin
                        // empty params closes the pair stream, empty stdin ends the request
                        if (rec_kind == KIND_PARAMS)
                        begin
                            fire = 1'b1;
                            ev   = (pair_at == LEN_NAME) ? EV_PARAMS_DONE : EV_PARAMS_ERR;
                            clear_pairs();
                        end
                        else if (rec_kind == KIND_STDIN)
                        begin
                            fire = 1'b1;
                            ev   = EV_REQ_DONE;
                        end
                        rec_at = (pad_left != 0) ? AT_PAD : AT_HEADER;
                    end
                end
                else
                    hdr_idx++;
            end
            AT_BODY:
            begin
                if (rec_kind == KIND_BEGIN)
                begin
                    if (body_idx == 16'd0)
                        begin_role = {b, 8'h00};
                    else if (body_idx == 16'd1)
                        begin_role = {begin_role[15:8], b};
                    else if (body_idx == 16'd2 && body_left >= BEGIN_MIN_LEFT &&
                             begin_role == ROLE_RESPONDER)
                    begin
                        keep_conn = (b == FLAG_KEEP);
                        fire      = 1'b1;
                        ev        = EV_BEGIN_OK;
                    end
                end
                else if (rec_kind == KIND_PARAMS)
                    fire = decode_pair_byte(b, ev);
                else if (rec_kind == KIND_STDIN)
                begin
                    fire = 1'b1;
                    ev   = EV_STDIN_BYTE;
                end
                body_idx++;
                body_left--;
                if (body_left == 0)
                    rec_at = (pad_left != 0) ? AT_PAD : AT_HEADER;
            end
            default:
            begin
                pad_left--;
                if (pad_left == 0)
                    rec_at = AT_HEADER;
            end
        endcase
        if (fire)
            ev_pending.push_back(ev);
    endfunction

    // one byte transfer on the input channel, after a random gap when in_idle is set
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = in_idle ? int'($urandom_range(0, 16)) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        bytes_sent++;
        step_deframer(b);
    endtask

    // header with random filler bytes, then body, then padding
    task automatic send_record(input logic [7:0] kind, input byte_q_t body,
                               input logic [7:0] pad);
        logic [15:0] len;
        len = 16'(body.size());
        send_byte(8'($urandom));
        send_byte(kind);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(pad);
        send_byte(8'($urandom));
        foreach (body[i])
            send_byte(body[i]);
        repeat (pad) send_byte(8'($urandom));
    endtask

    task automatic add_random(input int n);
        repeat (n) body_q.push_back(8'($urandom));
    endtask

    // pair length, one byte or four bytes with the top bit set
    task automatic add_length(input logic [30:0] len, input bit ext);
        if (!ext && len < 31'd128)
            body_q.push_back(len[7:0]);
        else
        begin
            body_q.push_back({1'b1, len[30:24]});
            body_q.push_back(len[23:16]);
            body_q.push_back(len[15:8]);
            body_q.push_back(len[7:0]);
        end
    endtask

    task automatic add_pair(input int nlen, input int vlen, input bit next, input bit vext);
        add_length(31'(nlen), next);
        add_length(31'(vlen), vext);
        add_random(nlen);
        add_random(vlen);
    endtask

    // role, flags, then filler, cut to the given length
    task automatic add_begin_body(input logic [15:0] role, input logic [7:0] flags,
                                  input int len);
        body_q.push_back(role[15:8]);
        body_q.push_back(role[7:0]);
        body_q.push_back(flags);
        add_random((len > 3) ? len - 3 : 0);
        while (body_q.size() > len)
            void'(body_q.pop_back());
    endtask

    function automatic int rand_len();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(120, 140))
                                           : int'($urandom_range(0, 8));
    endfunction

    // begin-request records: accepted roles, other roles, short bodies
    task automatic test_begin_request();
        body_q.delete(); add_begin_body(ROLE_RESPONDER, FLAG_KEEP, 8);
        send_record(KIND_BEGIN, body_q, 8'd0);
        body_q.delete(); add_begin_body(ROLE_RESPONDER, 8'h00, 8);
        send_record(KIND_BEGIN, body_q, 8'd3);
        body_q.delete(); add_begin_body(16'h0002, FLAG_KEEP, 8);
        send_record(KIND_BEGIN, body_q, 8'd0);
        body_q.delete(); add_begin_body(ROLE_RESPONDER, FLAG_KEEP, 7);
        send_record(KIND_BEGIN, body_q, 8'd1);
        body_q.delete(); add_begin_body(16'h0101, FLAG_KEEP, 8);
        send_record(KIND_BEGIN, body_q, 8'd0);
        body_q.delete(); add_begin_body(ROLE_RESPONDER, 8'hff, 12);
        send_record(KIND_BEGIN, body_q, 8'd0);
        send_record(KIND_BEGIN, no_body, 8'd0);
    endtask

    // params pairs: short, empty, long lengths, split records, done and error
    task automatic test_params_pairs();
        byte_q_t head;
        byte_q_t tail;
        body_q.delete();
        add_pair(3, 5, 1'b0, 1'b0);
        add_pair(0, 4, 1'b0, 1'b0);
        add_pair(2, 0, 1'b0, 1'b0);
        add_pair(0, 0, 1'b0, 1'b0);
        send_record(KIND_PARAMS, body_q, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
        // four-byte lengths, including zero written in the long form
        body_q.delete();
        add_pair(3, 130, 1'b1, 1'b0);
        add_pair(0, 0, 1'b1, 1'b1);
        send_record(KIND_PARAMS, body_q, 8'd2);
        send_record(KIND_PARAMS, no_body, 8'd0);
        // one pair spread over two records
        body_q.delete();
        add_pair(4, 6, 1'b0, 1'b0);
        head = body_q[0:4];
        tail = body_q[5:$];
        send_record(KIND_PARAMS, head, 8'd0);
        send_record(KIND_PARAMS, tail, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
        // name cut short, then the decoder starts clean
        body_q.delete();
        add_length(31'd5, 1'b0);
        add_length(31'd2, 1'b0);
        add_random(3);
        send_record(KIND_PARAMS, body_q, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
        body_q.delete();
        add_pair(1, 1, 1'b0, 1'b0);
        send_record(KIND_PARAMS, body_q, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
        // largest name length, only a few name bytes follow
        body_q.delete();
        body_q.push_back(8'hff);
        body_q.push_back(8'hff);
        body_q.push_back(8'hff);
        body_q.push_back(8'hff);
        body_q.push_back(8'h00);
        add_random(4);
        send_record(KIND_PARAMS, body_q, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
        // long value length left incomplete
        body_q.delete();
        body_q.push_back(8'h01);
        body_q.push_back(8'h85);
        body_q.push_back(8'h00);
        send_record(KIND_PARAMS, body_q, 8'd0);
        send_record(KIND_PARAMS, no_body, 8'd0);
    endtask

    // stdin pass-through, extreme byte values, empty stdin, zero and full padding
    task automatic test_stdin();
        body_q.delete();
        body_q.push_back(8'h00);
        body_q.push_back(8'hff);
        body_q.push_back(8'h7f);
        body_q.push_back(8'h80);
        body_q.push_back(8'h55);
        body_q.push_back(8'haa);
        send_record(KIND_STDIN, body_q, 8'd0);
        body_q.delete();
        add_random(1);
        send_record(KIND_STDIN, body_q, 8'hff);
        send_record(KIND_STDIN, no_body, 8'd1);
        send_record(KIND_STDIN, no_body, 8'd0);
    endtask

    // records of other types are skipped whole, including a long body
    task automatic test_unknown_records();
        logic [7:0] unknown_kinds[5] = '{8'h00, 8'h02, 8'h03, 8'h06, 8'hff};
        foreach (unknown_kinds[i])
        begin
            body_q.delete();
            add_random($urandom_range(0, 5));
            send_record(unknown_kinds[i], body_q, 8'($urandom_range(0, 3)));
        end
        body_q.delete();
        add_random(300);
        send_record(8'h07, body_q, 8'd4);
    endtask

    // output held off for a long stretch while the input keeps streaming
    task automatic test_output_hold();
        in_idle     = 1'b0;
        hold_output = 1'b1;
        body_q.delete();
        add_random(60);
        send_record(KIND_STDIN, body_q, 8'd0);
        in_idle = 1'b1;
    endtask

    // mostly well-formed records with random content, some broken ones
    task automatic test_random_stream();
        int         start;
        int         pick;
        int         n;
        int         cut;
        logic [7:0] kind;
        logic [7:0] pad;
        byte_q_t    head;
        byte_q_t    tail;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // idling switched on and off in stretches
            if ($urandom_range(0, 15) == 0)
            begin
                in_idle  = 1'($urandom_range(0, 1));
                out_idle = 1'($urandom_range(0, 1));
            end
            pad  = ($urandom_range(0, 39) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            body_q.delete();
            if (pick < 35)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    add_pair(rand_len(), rand_len(), $urandom_range(0, 7) == 0,
                             $urandom_range(0, 7) == 0);
                if (body_q.size() > 1 && $urandom_range(0, 2) == 0)
                begin
                    cut  = $urandom_range(1, body_q.size() - 1);
                    head = body_q[0:cut-1];
                    tail = body_q[cut:$];
                    send_record(KIND_PARAMS, head, 8'd0);
                    send_record(KIND_PARAMS, tail, pad);
                end
                else
                    send_record(KIND_PARAMS, body_q, pad);
                if ($urandom_range(0, 1) == 0)
                    send_record(KIND_PARAMS, no_body, 8'($urandom_range(0, 3)));
            end
            else if (pick < 55)
            begin
                add_random($urandom_range(1, 24));
                send_record(KIND_STDIN, body_q, pad);
                if ($urandom_range(0, 6) == 0)
                    send_record(KIND_STDIN, no_body, 8'd0);
            end
            else if (pick < 67)
            begin
                add_begin_body(($urandom_range(0, 3) == 0) ? 16'($urandom) : ROLE_RESPONDER,
                               ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 1)),
                               ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 8);
                send_record(KIND_BEGIN, body_q, pad);
            end
            else if (pick < 77)
            begin
                do
                    kind = 8'($urandom);
                while (kind == KIND_BEGIN || kind == KIND_PARAMS || kind == KIND_STDIN);
                add_random($urandom_range(0, 16));
                send_record(kind, body_q, pad);
            end
            else if (pick < 87)
            begin
                // garbage bodies or a pair cut off before its end
                if ($urandom_range(0, 1) == 0)
                    add_random($urandom_range(1, 10));
                else
                begin
                    add_pair(rand_len(), rand_len(), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0);
                    n = $urandom_range(1, body_q.size());
                    repeat (n) void'(body_q.pop_back());
                    if (body_q.size() == 0)
                        add_random(1);
                end
                send_record(KIND_PARAMS, body_q, pad);
                if ($urandom_range(0, 9) < 7)
                    send_record(KIND_PARAMS, no_body, 8'd0);
            end
            else if (pick < 93)
                send_record(KIND_PARAMS, no_body, pad);
            else
                send_record(KIND_STDIN, no_body, pad);
        end
    endtask

    // output side: random stalls, then check each event transfer in order
    initial
    begin : event_sink
        int         stall;
        logic [3:0] want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = out_idle ? int'($urandom_range(0, 16)) : 0;
            if (hold_output)
            begin
                stall       = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            if (ev_pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: event_res expected none, actual %0d", $time, out_ch.event_res);
            end
            else
            begin
                want = ev_pending.pop_front();
                if (out_ch.event_res !== want)
                begin
                    mismatches++;
                    $display("%0t: event_res expected %0d, actual %0d",
                             $time, want, out_ch.event_res);
                end
            end
        end
    end

    // reset, tests in turn, drain and verdict
    initial
    begin
        clear_deframer();
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_begin_request();
        test_params_pairs();
        test_stdin();
        test_unknown_records();
        test_output_hold();
        test_random_stream();

        in_ch.valid <= 1'b0;
        while (ev_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_fastcgi_record_deframer: done, clean");
        else
            $display("tb_fastcgi_record_deframer: done, errors");
        $finish;
    end

endmodule
